// ----- sv/sfd_pkg.sv -----
package sfd_pkg;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [15:0] SYNC_RESET = 16'hCDAB;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CRC_ERR   = 2'd1,
    ST_COUNT_ERR = 2'd2
  } sfd_status_e;

  // one result as it travels from the parser to the output stage
  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [9:0]  offset;
    logic [3:0]  count;
    logic        count_err;
    logic [15:0] rcrc;
    logic [15:0] ccrc;
  } sfd_rec_t;

  // crc-16/modbus, one byte, lsb first
  function automatic logic [15:0] sfd_crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

// ----- sv/sfd_front.sv -----
module sfd_front #(
  parameter int unsigned HEADER_BYTES  = 6,
  parameter int unsigned COMMAND_BYTES = 18,
  parameter int unsigned MAX_COMMANDS  = 15
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_data_i,
  input  logic             accept_i,
  input  logic [7:0]       rx_byte_i,
  output logic             push_o,
  output sfd_pkg::sfd_rec_t rec_o
);
  import sfd_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_HEADER,
    PH_COMMANDS,
    PH_CRC_LO,
    PH_CRC_HI
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] sync_q;
  logic [7:0]  prev_q, prev_d;
  logic        prev_valid_q, prev_valid_d;
  logic [15:0] prev_crc_q, prev_crc_d;
  logic [15:0] crc_q, crc_d;
  logic [9:0]  cnt_q, cnt_d;
  logic [3:0]  count_q, count_d;
  logic [7:0]  low_q, low_d;

  logic [15:0] crc_base, crc_new;
  logic [9:0]  cnt_inc, payload_end;
  logic        push;
  sfd_rec_t    rec;

  assign crc_base    = (phase_q == PH_HUNT) ? prev_crc_q : crc_q;
  assign crc_new     = sfd_crc_feed(crc_base, rx_byte_i);
  assign prev_crc_d  = sfd_crc_feed(CRC_INIT, rx_byte_i);
  assign cnt_inc     = cnt_q + 10'd1;
  assign payload_end = 10'(HEADER_BYTES) + 10'(count_q) * 10'(COMMAND_BYTES);

  always_comb begin
    phase_d      = phase_q;
    prev_d       = prev_q;
    prev_valid_d = prev_valid_q;
    crc_d        = crc_q;
    cnt_d        = cnt_q;
    count_d      = count_q;
    low_d        = low_q;
    push         = 1'b0;
    rec          = '0;
    rec.offset   = cnt_q;
    unique case (phase_q)
      PH_HEADER: begin
        crc_d = crc_new;
        if (cnt_q == 10'd4) count_d = rx_byte_i[3:0];
        cnt_d    = cnt_inc;
        push     = 1'b1;
        rec.kind = KIND_PAYLOAD;
        rec.data = rx_byte_i;
        if (cnt_inc >= 10'(HEADER_BYTES)) begin
          if (count_d > 4'(MAX_COMMANDS)) begin
            // header announces too many records: report and drop the frame
            rec.kind      = KIND_STATUS;
            rec.data      = 8'h00;
            rec.count_err = 1'b1;
            rec.ccrc      = crc_new;
            phase_d       = PH_HUNT;
            prev_valid_d  = 1'b0;
            prev_d        = 8'h00;
          end else if (count_d == 4'd0) begin
            phase_d = PH_CRC_LO;
          end else begin
            phase_d = PH_COMMANDS;
          end
        end
        rec.count = count_d;
      end
      PH_COMMANDS: begin
        crc_d     = crc_new;
        cnt_d     = cnt_inc;
        push      = 1'b1;
        rec.kind  = KIND_PAYLOAD;
        rec.data  = rx_byte_i;
        rec.count = count_q;
        if (cnt_inc >= payload_end) phase_d = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        low_d   = rx_byte_i;
        cnt_d   = cnt_inc;
        phase_d = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        push         = 1'b1;
        rec.kind     = KIND_STATUS;
        rec.count    = count_q;
        rec.rcrc     = {rx_byte_i, low_q};
        rec.ccrc     = crc_q;
        phase_d      = PH_HUNT;
        prev_valid_d = 1'b0;
        prev_d       = 8'h00;
      end
      default: begin
        if (prev_valid_q && ({rx_byte_i, prev_q} == sync_q)) begin
          // prev_crc_q already holds the crc over the first sync byte
          crc_d        = crc_new;
          cnt_d        = 10'd2;
          count_d      = 4'd0;
          low_d        = 8'h00;
          prev_valid_d = 1'b0;
          phase_d      = PH_HEADER;
        end else begin
          prev_d       = rx_byte_i;
          prev_valid_d = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      sync_q       <= SYNC_RESET;
      prev_q       <= 8'h00;
      prev_valid_q <= 1'b0;
      prev_crc_q   <= CRC_INIT;
      crc_q        <= CRC_INIT;
      cnt_q        <= '0;
      count_q      <= '0;
      low_q        <= '0;
    end else begin
      if (cfg_we_i) sync_q <= cfg_data_i;
      if (accept_i) begin
        phase_q      <= phase_d;
        prev_q       <= prev_d;
        prev_valid_q <= prev_valid_d;
        prev_crc_q   <= prev_crc_d;
        crc_q        <= crc_d;
        cnt_q        <= cnt_d;
        count_q      <= count_d;
        low_q        <= low_d;
      end
    end
  end

  assign push_o = accept_i & push;
  assign rec_o  = rec;

endmodule

// ----- sv/sfd_queue.sv -----
module sfd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sfd_pkg::sfd_rec_t rec_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output sfd_pkg::sfd_rec_t rec_o
);
  import sfd_pkg::*;

  sfd_rec_t            entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr_q, rptr_q;
  logic [QCNT_W-1:0]   fill_q;
  logic                do_push, do_pop;

  assign full_o  = (fill_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (fill_q != '0);
  assign rec_o   = entry_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wptr_q] <= rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + QPTR_W'(1);
      if (do_pop)  rptr_q <= rptr_q + QPTR_W'(1);
      unique case ({do_push, do_pop})
        2'b10:   fill_q <= fill_q + QCNT_W'(1);
        2'b01:   fill_q <= fill_q - QCNT_W'(1);
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

// ----- sv/sfd_back.sv -----
module sfd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  sfd_pkg::sfd_rec_t rec_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              result_kind_o,
  output logic [7:0]        data_byte_o,
  output logic [9:0]        frame_offset_o,
  output logic [3:0]        command_count_o,
  output logic [1:0]        frame_status_o,
  output logic [15:0]       received_crc_o,
  output logic [15:0]       computed_crc_o
);
  import sfd_pkg::*;

  logic        out_valid_q;
  logic        load;
  sfd_status_e status;

  assign load  = valid_i & (~out_valid_q | ~out_stall_i);
  assign pop_o = load;

  always_comb begin
    priority if (rec_i.kind == KIND_PAYLOAD) status = ST_OK;
    else if (rec_i.count_err)                status = ST_COUNT_ERR;
    else if (rec_i.rcrc == rec_i.ccrc)       status = ST_OK;
    else                                     status = ST_CRC_ERR;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (~out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      result_kind_o   <= rec_i.kind;
      data_byte_o     <= rec_i.data;
      frame_offset_o  <= rec_i.offset;
      command_count_o <= rec_i.count;
      frame_status_o  <= status;
      received_crc_o  <= rec_i.rcrc;
      computed_crc_o  <= rec_i.ccrc;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- sv/sync_frame_deframer_crc16.sv -----
// channel   direction  handshake               payload
// in        input      in_valid_i / in_stall_o   rx_byte_i
// out       output     out_valid_o / out_stall_i result_kind_o .. computed_crc_o
// cfg       input      cfg_valid_i / cfg_ready_o cfg_data_i (sync word)
//
// one byte is taken every cycle while in_stall_o is low; the parser and its
// byte-wide crc update finish a byte in the cycle it is taken, and a result
// reaches the output through a four-entry queue and the output register.
// reset puts the parser in sync hunt with sync word 0xcdab and the queue empty.
// in_stall_o rises only when the queue is full, which needs out_stall_i to hold back the output.
module sync_frame_deframer_crc16 #(
  parameter int unsigned HEADER_BYTES  = 6,
  parameter int unsigned COMMAND_BYTES = 18,
  parameter int unsigned MAX_COMMANDS  = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [7:0]  data_byte_o,
  output logic [9:0]  frame_offset_o,
  output logic [3:0]  command_count_o,
  output logic [1:0]  frame_status_o,
  output logic [15:0] received_crc_o,
  output logic [15:0] computed_crc_o
);
  import sfd_pkg::*;

  logic     accept, push, full, q_valid, pop;
  sfd_rec_t push_rec, q_rec;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign accept      = in_valid_i & ~full;

  sfd_front #(
    .HEADER_BYTES (HEADER_BYTES),
    .COMMAND_BYTES(COMMAND_BYTES),
    .MAX_COMMANDS (MAX_COMMANDS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_valid_i & cfg_ready_o),
    .cfg_data_i(cfg_data_i),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .push_o    (push),
    .rec_o     (push_rec)
  );

  sfd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (push_rec),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .rec_o  (q_rec)
  );

  sfd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .rec_i          (q_rec),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_kind_o  (result_kind_o),
    .data_byte_o    (data_byte_o),
    .frame_offset_o (frame_offset_o),
    .command_count_o(command_count_o),
    .frame_status_o (frame_status_o),
    .received_crc_o (received_crc_o),
    .computed_crc_o (computed_crc_o)
  );

endmodule
